[rtl/modified_utf8_decode_hash_defines.svh]
// Assertion helpers used by the decoder RTL.
`ifndef MODIFIED_UTF8_DECODE_HASH_DEFINES_SVH
`define MODIFIED_UTF8_DECODE_HASH_DEFINES_SVH

// Checked on every rising clock edge once reset is released.
`define MU8DH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MU8DH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mu8dh_pkg.sv]
package mu8dh_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int HASH_W  = 32;
    localparam int COUNT_W = 16;

    localparam logic [HASH_W-1:0]  HASH_MUL  = 32'd37;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Lead byte decode: bit 7 marks a multi-byte lead, bit 5 a three-byte one.
    localparam int LEAD_BIT  = 7;
    localparam int LONG_BIT  = 5;

    typedef struct packed {
        logic               unit_valid;
        logic [UNIT_W-1:0]  code_unit;
        logic               string_done;
        logic [HASH_W-1:0]  hash_value;
        logic [COUNT_W-1:0] unit_count;
        logic               truncated;
    } result_t;

    // Wrapping hash*37 + unit.
    function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] hash,
                                                   input logic [UNIT_W-1:0] unit);
        logic [HASH_W-1:0] prod;
        begin
            prod = HASH_W'(hash * HASH_MUL);
            hash_step = HASH_W'(prod + {{(HASH_W-UNIT_W){1'b0}}, unit});
        end
    endfunction

endpackage

[rtl/mu8dh_if.sv]
interface mu8dh_byte_if;
    logic                          valid;
    logic                          ready;
    logic [mu8dh_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mu8dh_result_if;
    logic                          valid;
    logic                          ready;
    logic                          unit_valid;
    logic [mu8dh_pkg::UNIT_W-1:0]  code_unit;
    logic                          string_done;
    logic [mu8dh_pkg::HASH_W-1:0]  hash_value;
    logic [mu8dh_pkg::COUNT_W-1:0] unit_count;
    logic                          truncated;

    modport source (output valid, output unit_valid, output code_unit, output string_done,
                    output hash_value, output unit_count, output truncated, input ready);
    modport sink   (input valid, input unit_valid, input code_unit, input string_done,
                    input hash_value, input unit_count, input truncated, output ready);
endinterface

[rtl/modified_utf8_decode_hash.sv]
// Modified UTF-8 decoder with running hash.
//
// bytes:   one string byte per transfer; a zero byte terminates the string.
// results: one transfer per completed 16-bit unit (unit_valid=1, updated hash
//          and count) and one per terminator (string_done=1, final hash and
//          count, truncated=1 if a multi-byte sequence was cut short).
//          Lead and middle bytes that do not finish a unit give no transfer.
//
// Each byte passes an input register, then the decode / hash*37+unit update
// writes the state and the result register in the same cycle. A result is
// valid once its byte has passed both registers, and transfers at the next
// edge at which the receiver is ready. One byte per cycle is sustained while
// results.ready is high; the limit is the hash multiply-add feeding back.
//
// Reset clears the decode state, the hash, the count and both valid flags.
// When the receiver holds results.ready low with a result waiting, the input
// register stops advancing and bytes.ready drops once it is full; nothing is
// lost or repeated. A terminator also clears the state for the next string.
`include "modified_utf8_decode_hash_defines.svh"

module modified_utf8_decode_hash (
    input  logic                 clk,
    input  logic                 rst_n,
    mu8dh_byte_if.sink           bytes,
    mu8dh_result_if.source       results
);

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ONE  = 2'd1,
        PEND_TWO  = 2'd2
    } pend_t;

    logic                          in_valid_reg;
    logic [mu8dh_pkg::BYTE_W-1:0]  in_byte_reg;

    pend_t                         pend_reg,  pend_next;
    logic [mu8dh_pkg::UNIT_W-1:0]  part_reg,  part_next;
    logic [mu8dh_pkg::HASH_W-1:0]  hash_reg,  hash_next;
    logic [mu8dh_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                          out_valid_reg, out_valid_next;
    mu8dh_pkg::result_t            res_reg, res_next;

    logic                          advance;
    logic                          fire;
    logic                          produce;
    logic                          complete;
    logic                          is_term;
    logic [mu8dh_pkg::UNIT_W-1:0]  unit;

    // The decode stage moves whenever the result register is free or drains.
    assign advance     = !out_valid_reg || results.ready;
    assign fire        = in_valid_reg && advance;
    assign bytes.ready = !in_valid_reg || advance;
    assign is_term     = (in_byte_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            in_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            in_byte_reg <= bytes.data_byte;
        end
    end

    always_comb
    begin
        pend_next  = pend_reg;
        part_next  = part_reg;
        hash_next  = hash_reg;
        count_next = count_reg;
        res_next   = res_reg;
        produce    = 1'b0;
        complete   = 1'b0;
        unit       = {{(mu8dh_pkg::UNIT_W-mu8dh_pkg::BYTE_W){1'b0}}, in_byte_reg};

        if (fire)
        begin
            if (is_term)
            begin
                produce              = 1'b1;
                res_next.unit_valid  = 1'b0;
                res_next.code_unit   = '0;
                res_next.string_done = 1'b1;
                res_next.hash_value  = hash_reg;
                res_next.unit_count  = count_reg;
                res_next.truncated   = (pend_reg != PEND_NONE);
                pend_next            = PEND_NONE;
                part_next            = '0;
                hash_next            = '0;
                count_next           = '0;
            end
            else
            begin
                unique case (pend_reg)
                    PEND_TWO:
                    begin
                        part_next = part_reg | {4'b0, in_byte_reg[5:0], 6'b0};
                        pend_next = PEND_ONE;
                    end
                    PEND_ONE:
                    begin
                        unit      = part_reg | {10'b0, in_byte_reg[5:0]};
                        complete  = 1'b1;
                        pend_next = PEND_NONE;
                        part_next = '0;
                    end
                    PEND_NONE:
                    begin
                        if (in_byte_reg[mu8dh_pkg::LEAD_BIT])
                        begin
                            if (in_byte_reg[mu8dh_pkg::LONG_BIT])
                            begin
                                part_next = {in_byte_reg[3:0], 12'b0};
                                pend_next = PEND_TWO;
                            end
                            else
                            begin
                                part_next = {5'b0, in_byte_reg[4:0], 6'b0};
                                pend_next = PEND_ONE;
                            end
                        end
                        else
                        begin
                            complete = 1'b1;
                        end
                    end
                    default:
                    begin
                        pend_next = PEND_NONE;
                        part_next = '0;
                    end
                endcase

                if (complete)
                begin
                    hash_next = mu8dh_pkg::hash_step(hash_reg, unit);
                    if (count_reg != mu8dh_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    produce              = 1'b1;
                    res_next.unit_valid  = 1'b1;
                    res_next.code_unit   = unit;
                    res_next.string_done = 1'b0;
                    res_next.hash_value  = hash_next;
                    res_next.unit_count  = count_next;
                    res_next.truncated   = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= PEND_NONE;
            part_reg      <= '0;
            hash_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            part_reg      <= part_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.unit_valid  = res_reg.unit_valid;
    assign results.code_unit   = res_reg.code_unit;
    assign results.string_done = res_reg.string_done;
    assign results.hash_value  = res_reg.hash_value;
    assign results.unit_count  = res_reg.unit_count;
    assign results.truncated   = res_reg.truncated;

    `MU8DH_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |-> !out_valid_reg, "result valid in reset")
    `MU8DH_ASSERT(a_done_xor_unit, out_valid_reg |-> (res_reg.unit_valid != res_reg.string_done),
                  "result must be exactly one of unit or terminator")
    `MU8DH_ASSERT(a_trunc_only_done, (out_valid_reg && res_reg.truncated) |-> res_reg.string_done,
                  "truncated flag without terminator")
    `MU8DH_ASSERT(a_term_clears, (fire && is_term) |=>
                  (pend_reg == PEND_NONE && hash_reg == '0 && count_reg == '0 && part_reg == '0),
                  "state not cleared after terminator")
    `MU8DH_ASSERT(a_count_sat, (count_reg == mu8dh_pkg::COUNT_MAX && !(fire && is_term)) |=>
                  (count_reg == mu8dh_pkg::COUNT_MAX), "unit count left saturation")

endmodule
